### sv/ppts_pkg.sv
// Shared types and constants for the preemptive priority task scheduler.
package ppts_pkg;

    // Default sizing of the scheduler storage
    localparam int QUEUE_DEPTH_DEF = 3;
    localparam int STACK_DEPTH_DEF = 9;
    localparam int ID_WIDTH_DEF    = 8;

    // Fixed layout of the request and result fields
    localparam int NUM_LEVELS  = 3;
    localparam int PRIO_W      = 2;
    localparam int PAY_ID_W    = 8;
    localparam int STATUS_W    = 3;

    // Request modes
    localparam logic MODE_ARRIVAL  = 1'b0;
    localparam logic MODE_COMPLETE = 1'b1;

    // Lowest priority level
    localparam logic [PRIO_W-1:0] PRIO_LOWEST = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE_DONE  = 3'd4;

    // Incoming request
    typedef struct packed {
        logic                mode;
        logic [PRIO_W-1:0]   arrival_priority;
        logic [PAY_ID_W-1:0] arrival_task_id;
    } t_req;

    // Outgoing result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                preempted;
        logic                running_valid;
        logic [PAY_ID_W-1:0] running_task_id;
        logic [PRIO_W-1:0]   running_priority;
        logic                running_from_stack;
    } t_rsp;

endpackage

### sv/preemptive_priority_task_scheduler.sv
// Top level of the preemptive priority task scheduler: queues, preemption stack, run slot.
//
// One request (task arrival or completion of the running task) is taken per clock cycle and
// its result appears in the result register on the next edge; a request is taken whenever the
// result register is empty or its result is taken in the same cycle. Each of the three
// priority queues and the preemption stack sits in a small memory with registered read: the
// head of every queue and the stack top are prefetched, with write-through when
// the entry being fetched is written in the same cycle, so a request never waits on a memory.
// No clearing pass follows reset; the block takes requests as soon as reset is released.
// An arrival is rejected once queues and stack together hold 3*QUEUE_DEPTH tasks.
module preemptive_priority_task_scheduler #(
    parameter int QUEUE_DEPTH = ppts_pkg::QUEUE_DEPTH_DEF,
    parameter int STACK_DEPTH = ppts_pkg::STACK_DEPTH_DEF,
    parameter int ID_WIDTH    = ppts_pkg::ID_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  ppts_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output ppts_pkg::t_rsp o_rsp
);

    localparam int NL   = ppts_pkg::NUM_LEVELS;
    localparam int PW   = ppts_pkg::PRIO_W;
    localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QSW  = QCW + 1;
    localparam int SIW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW  = $clog2(STACK_DEPTH + 1);
    localparam int TW   = $clog2(NL * QUEUE_DEPTH + STACK_DEPTH + 1);
    localparam int CAP  = NL * QUEUE_DEPTH;
    localparam int SEW  = PW + ID_WIDTH;

    // Queue state
    logic [QIW-1:0]      r_qhead [NL];
    logic [QIW-1:0]      n_qhead [NL];
    logic [QCW-1:0]      r_qcnt  [NL];
    logic [QCW-1:0]      n_qcnt  [NL];
    logic [ID_WIDTH-1:0] r_qrd   [NL];
    logic [QIW-1:0]      w_qtail [NL];
    logic [QIW-1:0]      w_qinc  [NL];
    logic [NL-1:0]       w_qwe;

    // Stack state
    logic [SCW-1:0]      r_stk_cnt;
    logic [SCW-1:0]      n_stk_cnt;
    logic [SEW-1:0]      r_stk_rd;
    logic                w_swe;
    logic [SIW-1:0]      w_swaddr;
    logic [SEW-1:0]      w_swdata;
    logic [SCW-1:0]      w_scnt_eff;
    logic [SIW-1:0]      w_srd_addr;

    // Run slot
    logic [ID_WIDTH-1:0] r_run_id;
    logic [ID_WIDTH-1:0] n_run_id;
    logic [PW-1:0]       r_run_prio;
    logic [PW-1:0]       n_run_prio;
    logic                r_busy;
    logic                n_busy;
    logic                r_flag;
    logic                n_flag;

    // Request side
    logic                w_acc;
    logic [ID_WIDTH-1:0] w_id;
    logic [PW-1:0]       w_prio;
    logic [TW-1:0]       w_total;
    logic [ppts_pkg::STATUS_W-1:0] w_status;
    logic                w_preempted;

    // Result register
    logic                r_rsp_valid;
    ppts_pkg::t_rsp      r_rsp;
    logic [ppts_pkg::PAY_ID_W-1:0] w_run_id_out;

    // Take a request when the result register is free or drains this cycle
    assign o_req_stall = r_rsp_valid & i_rsp_stall;
    assign w_acc       = i_req_valid & ~o_req_stall;

    // Fit the request id to the stored id width, and the next run id back to the result field
    generate
        if (ID_WIDTH >= ppts_pkg::PAY_ID_W) begin : g_id_wide
            assign w_id         = ID_WIDTH'(i_req.arrival_task_id);
            assign w_run_id_out = n_run_id[ppts_pkg::PAY_ID_W-1:0];
        end else begin : g_id_narrow
            assign w_id         = i_req.arrival_task_id[ID_WIDTH-1:0];
            assign w_run_id_out = ppts_pkg::PAY_ID_W'(n_run_id);
        end
    endgenerate

    // Fold an out-of-range priority onto the lowest level
    assign w_prio = (i_req.arrival_priority > ppts_pkg::PRIO_LOWEST) ?
                    ppts_pkg::PRIO_LOWEST : i_req.arrival_priority;

    // Count all stored tasks
    assign w_total = TW'(r_qcnt[0]) + TW'(r_qcnt[1]) + TW'(r_qcnt[2]) + TW'(r_stk_cnt);

    // Tail position and head advance per queue
    always_comb begin
        logic [QSW-1:0] sum;
        for (int l = 0; l < NL; l++) begin
            sum = QSW'(r_qhead[l]) + QSW'(r_qcnt[l]);
            if (sum >= QSW'(QUEUE_DEPTH)) begin
                sum = sum - QSW'(QUEUE_DEPTH);
            end
            w_qtail[l] = sum[QIW-1:0];
            w_qinc[l]  = (r_qhead[l] == QIW'(QUEUE_DEPTH - 1)) ? '0 : r_qhead[l] + 1'b1;
        end
    end

    // Work out the next state and the result for one request
    always_comb begin
        logic [QCW-1:0]      cnt_after;
        logic [ID_WIDTH-1:0] head_val;
        logic                found;
        logic [PW-1:0]       lvl;

        n_qhead     = r_qhead;
        n_qcnt      = r_qcnt;
        w_qwe       = '0;
        n_stk_cnt   = r_stk_cnt;
        w_swe       = 1'b0;
        w_swaddr    = r_stk_cnt[SIW-1:0];
        w_swdata    = {r_run_prio, r_run_id};
        n_run_id    = r_run_id;
        n_run_prio  = r_run_prio;
        n_busy      = r_busy;
        n_flag      = r_flag;
        w_status    = ppts_pkg::ST_ADDED;
        w_preempted = 1'b0;
        cnt_after   = r_qcnt[w_prio];
        head_val    = r_qrd[w_prio];
        found       = 1'b0;
        lvl         = '0;

        if (i_req.mode == ppts_pkg::MODE_ARRIVAL) begin
            if (w_total >= TW'(CAP)) begin
                w_status = ppts_pkg::ST_REJECTED;
            end else begin
                // Append to own queue unless full
                if (r_qcnt[w_prio] < QCW'(QUEUE_DEPTH)) begin
                    w_qwe[w_prio] = 1'b1;
                    cnt_after     = r_qcnt[w_prio] + 1'b1;
                    w_status      = ppts_pkg::ST_ADDED;
                end else begin
                    w_status      = ppts_pkg::ST_QUEUE_FULL;
                end
                n_qcnt[w_prio] = cnt_after;
                if (r_qcnt[w_prio] == '0) begin
                    head_val = w_id;
                end
                // Preempt an idle slot or a lower-priority task
                if (!r_flag && cnt_after != '0) begin
                    if (!r_busy) begin
                        n_qhead[w_prio] = w_qinc[w_prio];
                        n_qcnt[w_prio]  = cnt_after - 1'b1;
                        n_run_id        = head_val;
                        n_run_prio      = w_prio;
                        n_busy          = 1'b1;
                    end else if (r_run_prio > w_prio && r_stk_cnt < SCW'(STACK_DEPTH)) begin
                        w_swe           = 1'b1;
                        n_stk_cnt       = r_stk_cnt + 1'b1;
                        w_preempted     = 1'b1;
                        n_qhead[w_prio] = w_qinc[w_prio];
                        n_qcnt[w_prio]  = cnt_after - 1'b1;
                        n_run_id        = head_val;
                        n_run_prio      = w_prio;
                    end
                end
            end
        end else if (!r_busy) begin
            w_status = ppts_pkg::ST_IDLE_DONE;
        end else begin
            w_status = ppts_pkg::ST_DONE;
            // Pick the nonempty queue with the highest priority (lowest level number)
            for (int l = NL - 1; l >= 0; l--) begin
                if (r_qcnt[l] != '0) begin
                    found = 1'b1;
                    lvl   = PW'(l);
                end
            end
            if (found) begin
                n_qhead[lvl] = w_qinc[lvl];
                n_qcnt[lvl]  = r_qcnt[lvl] - 1'b1;
                n_run_id     = r_qrd[lvl];
                n_run_prio   = lvl;
            end else if (r_stk_cnt != '0) begin
                n_stk_cnt    = r_stk_cnt - 1'b1;
                n_run_prio   = r_stk_rd[SEW-1:ID_WIDTH];
                n_run_id     = r_stk_rd[ID_WIDTH-1:0];
                n_flag       = 1'b1;
            end else begin
                n_busy       = 1'b0;
                n_run_id     = '0;
                n_run_prio   = '0;
                n_flag       = 1'b0;
            end
        end
    end

    // Queue memories with the head prefetched into a read register
    generate
        for (genvar g = 0; g < NL; g++) begin : g_queue
            logic [ID_WIDTH-1:0] r_mem [QUEUE_DEPTH];
            logic [QIW-1:0]      w_rd_addr;

            assign w_rd_addr = w_acc ? n_qhead[g] : r_qhead[g];

            always_ff @(posedge i_clk) begin
                if (w_acc && w_qwe[g]) begin
                    r_mem[w_qtail[g]] <= w_id;
                end
                if (w_acc && w_qwe[g] && w_qtail[g] == w_rd_addr) begin
                    r_qrd[g] <= w_id;
                end else begin
                    r_qrd[g] <= r_mem[w_rd_addr];
                end
            end
        end
    endgenerate

    // Stack memory with the top prefetched into a read register
    logic [SEW-1:0] r_stk_mem [STACK_DEPTH];

    assign w_scnt_eff = w_acc ? n_stk_cnt : r_stk_cnt;
    assign w_srd_addr = (w_scnt_eff == '0) ? '0 : SIW'(w_scnt_eff - 1'b1);

    always_ff @(posedge i_clk) begin
        if (w_acc && w_swe) begin
            r_stk_mem[w_swaddr] <= w_swdata;
        end
        if (w_acc && w_swe && w_swaddr == w_srd_addr) begin
            r_stk_rd <= w_swdata;
        end else begin
            r_stk_rd <= r_stk_mem[w_srd_addr];
        end
    end

    // Commit state on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NL; l++) begin
                r_qhead[l] <= '0;
                r_qcnt[l]  <= '0;
            end
            r_stk_cnt  <= '0;
            r_run_id   <= '0;
            r_run_prio <= '0;
            r_busy     <= 1'b0;
            r_flag     <= 1'b0;
        end else if (w_acc) begin
            r_qhead    <= n_qhead;
            r_qcnt     <= n_qcnt;
            r_stk_cnt  <= n_stk_cnt;
            r_run_id   <= n_run_id;
            r_run_prio <= n_run_prio;
            r_busy     <= n_busy;
            r_flag     <= n_flag;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_acc) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // Load the result fields, reading the run slot as it will stand after the request
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rsp.status             <= w_status;
            r_rsp.preempted          <= w_preempted;
            r_rsp.running_valid      <= n_busy;
            r_rsp.running_priority   <= n_run_prio;
            r_rsp.running_from_stack <= n_flag;
            r_rsp.running_task_id    <= w_run_id_out;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### sim/ppts_sched_checker.sv
`timescale 1ns / 1ps
// Scheduler checker: watches both channels, predicts each result and compares it.
module ppts_sched_checker
    import ppts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_err_count,
    output int   o_pending
);

    localparam int QD        = QUEUE_DEPTH_DEF;
    localparam int SD        = STACK_DEPTH_DEF;
    localparam int IDW       = ID_WIDTH_DEF;
    localparam int MAX_TASKS = 3;
    localparam logic [PAY_ID_W-1:0] ID_MASK = PAY_ID_W'((64'd1 << IDW) - 64'd1);

    // Shadow copy of the scheduler state
    logic [PAY_ID_W-1:0] lvl_q [NUM_LEVELS][QD];
    int                  lvl_head [NUM_LEVELS];
    int                  lvl_cnt [NUM_LEVELS];
    logic [PRIO_W-1:0]   stk_prio [SD];
    logic [PAY_ID_W-1:0] stk_id [SD];
    int                  stk_cnt;
    logic [PRIO_W-1:0]   cur_prio;
    logic [PAY_ID_W-1:0] cur_id;
    bit                  cur_busy;
    bit                  from_stack_flag;

    // Predicted outcomes still waiting for the block
    t_rsp sched_outcome_q[$];
    t_rsp want;
    int   mismatches = 0;

    // Take the head of one priority queue
    function automatic logic [PAY_ID_W-1:0] pop_level(int lvl);
        logic [PAY_ID_W-1:0] id;
        id            = lvl_q[lvl][lvl_head[lvl]];
        lvl_head[lvl] = (lvl_head[lvl] + 1) % QD;
        lvl_cnt[lvl]--;
        return id;
    endfunction

    // Apply one request to the shadow state and return the scheduler outcome
    function automatic t_rsp schedule_request(t_req r);
        t_rsp                res;
        int                  lvl;
        int                  total;
        int                  prio;
        logic [PAY_ID_W-1:0] id;
        res  = '0;
        prio = (r.arrival_priority > PRIO_LOWEST) ? int'(PRIO_LOWEST)
                                                  : int'(r.arrival_priority);
        id   = r.arrival_task_id & ID_MASK;
        if (r.mode == MODE_ARRIVAL) begin
            total = lvl_cnt[0] + lvl_cnt[1] + lvl_cnt[2] + stk_cnt;
            if (total >= MAX_TASKS * QD) begin
                res.status = ST_REJECTED;
            end else begin
                if (lvl_cnt[prio] < QD) begin
                    lvl_q[prio][(lvl_head[prio] + lvl_cnt[prio]) % QD] = id;
                    lvl_cnt[prio]++;
                    res.status = ST_ADDED;
                end else begin
                    res.status = ST_QUEUE_FULL;
                end
                // Preempt an idle slot or a lower-priority task
                if (!from_stack_flag && lvl_cnt[prio] > 0) begin
                    if (!cur_busy) begin
                        cur_id   = pop_level(prio);
                        cur_prio = PRIO_W'(prio);
                        cur_busy = 1'b1;
                    end else if (int'(cur_prio) > prio && stk_cnt < SD) begin
                        stk_prio[stk_cnt] = cur_prio;
                        stk_id[stk_cnt]   = cur_id;
                        stk_cnt++;
                        res.preempted = 1'b1;
                        cur_id   = pop_level(prio);
                        cur_prio = PRIO_W'(prio);
                    end
                end
            end
        end else if (!cur_busy) begin
            res.status = ST_IDLE_DONE;
        end else begin
            res.status = ST_DONE;
            lvl = 0;
            while (lvl < NUM_LEVELS && lvl_cnt[lvl] == 0) lvl++;
            // Refill from the queues first, then from the stack top
            if (lvl < NUM_LEVELS) begin
                cur_id   = pop_level(lvl);
                cur_prio = PRIO_W'(lvl);
            end else if (stk_cnt > 0) begin
                stk_cnt--;
                cur_id          = stk_id[stk_cnt];
                cur_prio        = stk_prio[stk_cnt];
                from_stack_flag = 1'b1;
            end else begin
                cur_busy        = 1'b0;
                cur_id          = '0;
                cur_prio        = '0;
                from_stack_flag = 1'b0;
            end
        end
        res.running_valid      = cur_busy;
        res.running_task_id    = cur_busy ? cur_id : '0;
        res.running_priority   = cur_busy ? cur_prio : '0;
        res.running_from_stack = from_stack_flag;
        return res;
    endfunction

    // Report one field that differs
    task automatic note_mismatch(string field, int exp_val, int act_val);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
    endtask

    // Track requests and check results at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                lvl_head[l] = 0;
                lvl_cnt[l]  = 0;
            end
            stk_cnt         = 0;
            cur_prio        = '0;
            cur_id          = '0;
            cur_busy        = 1'b0;
            from_stack_flag = 1'b0;
            sched_outcome_q.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (sched_outcome_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, actual %p", $time, i_rsp);
                end else begin
                    want = sched_outcome_q.pop_front();
                    if (i_rsp.status !== want.status)
                        note_mismatch("status", int'(want.status), int'(i_rsp.status));
                    if (i_rsp.preempted !== want.preempted)
                        note_mismatch("preempted", int'(want.preempted),
                                      int'(i_rsp.preempted));
                    if (i_rsp.running_valid !== want.running_valid)
                        note_mismatch("running_valid", int'(want.running_valid),
                                      int'(i_rsp.running_valid));
                    if (i_rsp.running_task_id !== want.running_task_id)
                        note_mismatch("running_task_id", int'(want.running_task_id),
                                      int'(i_rsp.running_task_id));
                    if (i_rsp.running_priority !== want.running_priority)
                        note_mismatch("running_priority", int'(want.running_priority),
                                      int'(i_rsp.running_priority));
                    if (i_rsp.running_from_stack !== want.running_from_stack)
                        note_mismatch("running_from_stack", int'(want.running_from_stack),
                                      int'(i_rsp.running_from_stack));
                end
            end
            // Queue the prediction for an accepted request at the tail
            if (i_req_valid && !i_req_stall) begin
                sched_outcome_q.insert(sched_outcome_q.size(), schedule_request(i_req));
            end
        end
        o_pending   <= sched_outcome_q.size();
        o_err_count <= mismatches;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives requests and result stalls into the scheduler and gives the verdict.
module tb_top;
    import ppts_pkg::*;

    localparam int RANDOM_REQUESTS  = 1300;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    t_req req;
    logic rsp_valid;
    logic rsp_stall;
    t_rsp rsp;
    int   err_count;
    int   pending;
    int   quiet_cycles = 0;
    bit   tx_no_gaps   = 1'b0;

    always #1 clk = ~clk;

    preemptive_priority_task_scheduler uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    ppts_sched_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_stall (req_stall),
        .i_req       (req),
        .i_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .i_rsp       (rsp),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    function automatic t_req make_req(logic m, logic [PRIO_W-1:0] p, logic [PAY_ID_W-1:0] id);
        t_req r;
        r.mode             = m;
        r.arrival_priority = p;
        r.arrival_task_id  = id;
        return r;
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input t_req r);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic await_all_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Result side: random stalls per result, bursts without stalls, two long hold-offs
    initial begin
        int hold;
        int rsp_taken;
        bit rx_no_stalls;
        rsp_taken    = 0;
        rx_no_stalls = 1'b0;
        rsp_stall <= 1'b0;
        forever begin
            if (rsp_taken % 50 == 0) rx_no_stalls = ($urandom_range(0, 3) == 0);
            if (rsp_taken == 300 || rsp_taken == 900) hold = LONG_HOLD_CYCLES;
            else hold = rx_no_stalls ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            rsp_taken++;
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Request side: reset, directed walk, random traffic, verdict
    initial begin
        t_req r;
        int   arrival_pct;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Completion while idle, then build up a preemption chain
        send_request(make_req(MODE_COMPLETE, 2'd3, 8'hFF));
        send_request(make_req(MODE_ARRIVAL, 2'd2, 8'h00));
        send_request(make_req(MODE_ARRIVAL, 2'd1, 8'hFF));
        send_request(make_req(MODE_ARRIVAL, 2'd0, 8'hA5));
        // Equal priority queues up; priority 3 folds into the lowest level
        send_request(make_req(MODE_ARRIVAL, 2'd0, 8'h5A));
        send_request(make_req(MODE_ARRIVAL, 2'd3, 8'h3C));
        send_request(make_req(MODE_ARRIVAL, 2'd0, 8'h11));
        send_request(make_req(MODE_ARRIVAL, 2'd0, 8'h22));
        // Own queue full, then fill storage and get rejected
        send_request(make_req(MODE_ARRIVAL, 2'd0, 8'h66));
        send_request(make_req(MODE_ARRIVAL, 2'd1, 8'h33));
        send_request(make_req(MODE_ARRIVAL, 2'd2, 8'h44));
        send_request(make_req(MODE_ARRIVAL, 2'd2, 8'h55));
        send_request(make_req(MODE_ARRIVAL, 2'd1, 8'h77));
        // Drain the queues until the stack top runs
        repeat (8) send_request(make_req(MODE_COMPLETE, 2'd0, 8'h00));
        // Arrival while running from the stack does not preempt
        send_request(make_req(MODE_ARRIVAL, 2'd0, 8'h80));
        repeat (4) send_request(make_req(MODE_COMPLETE, 2'd1, 8'h01));

        // Random traffic with a varying share of arrivals
        arrival_pct = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0) arrival_pct = $urandom_range(30, 80);
            if (n % 40 == 0) tx_no_gaps = ($urandom_range(0, 3) == 0);
            if (n == 500 || n == 1100) await_all_results();
            r.mode             = ($urandom_range(0, 99) < arrival_pct) ? MODE_ARRIVAL
                                                                       : MODE_COMPLETE;
            r.arrival_priority = PRIO_W'($urandom_range(0, 3));
            r.arrival_task_id  = PAY_ID_W'($urandom_range(0, 255));
            send_request(r);
        end

        await_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
